// File: src/text_console_writer_macros.svh
// Assertion macros used by the text console writer top level.
// Uses the enclosing module's clk_i and rst_ni; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tcw_pkg.sv
// Package for the text console writer: operation codes, payload words,
// and the command/status bundles between controller and datapath. No dependencies.
`default_nettype none

package tcw_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_WRITE_CURSOR = 2'd0;
  localparam logic [1:0] OP_WRITE_AT     = 2'd1;
  localparam logic [1:0] OP_READ         = 2'd2;

  // Character code that moves the cursor to the next row.
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Reset value of the default attribute register.
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

  // Input word.
  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] column;
    logic [4:0] row;
    logic [7:0] char_code;
    logic [7:0] attribute;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attribute;
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic       scrolled;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_read;
    logic sweep;
    logic sweep_clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic scroll_needed;
    logic sweep_last;
  } status_t;

endpackage

`default_nettype wire

// File: src/tcw_datapath.sv
// Datapath of the text console writer: cell memory, cursor, default attribute,
// sweep counter for clearing and scrolling, and the result register. Uses tcw_pkg.
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tcw_pkg::item_t   item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire tcw_pkg::cmd_t    cmd_i,
  output tcw_pkg::status_t      status_o,
  output tcw_pkg::result_t      result_o,
  output logic                  result_strobe_o
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int MOVE  = CELLS - COLUMNS;

  // Cell memory: attribute in the high byte, character in the low byte.
  logic [15:0] mem [CELLS];

  logic [1:0]    op_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [7:0]    char_q;
  logic [7:0]    attr_q;
  logic [CW-1:0] cur_col_q;
  logic [RW-1:0] cur_row_q;
  logic [7:0]    def_attr_q;
  logic [AW-1:0] sweep_cnt_q;
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_zero_q;
  logic [15:0]   rdata_q;
  tcw_pkg::result_t res_q;
  logic          strobe_q;

  logic [AW-1:0] cell_addr;
  logic          is_write;
  logic          is_read;
  logic          is_newline;
  logic [7:0]    eff_attr;
  logic          at_last_col;
  logic          at_last_row;
  logic          wrap;
  logic          scroll;
  logic [CW-1:0] next_col;
  logic [RW-1:0] next_row;
  logic          sweep_last;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic [AW-1:0] mem_ra;
  logic [CW-1:0] cap_col;
  logic [RW-1:0] cap_row;

  // Clamp a given position into the grid; cursor writes use the cursor.
  always_comb begin
    if (item_i.operation == tcw_pkg::OP_WRITE_CURSOR) begin
      cap_col = cur_col_q;
      cap_row = cur_row_q;
    end else begin
      cap_col = (32'(item_i.column) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(item_i.column);
      cap_row = (32'(item_i.row) >= ROWS) ? RW'(ROWS - 1) : RW'(item_i.row);
    end
  end

  // Decode of the captured word and the next cursor position.
  assign cell_addr   = AW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign is_write    = (op_q == tcw_pkg::OP_WRITE_CURSOR) || (op_q == tcw_pkg::OP_WRITE_AT);
  assign is_read     = (op_q == tcw_pkg::OP_READ);
  assign is_newline  = (char_q == tcw_pkg::NEWLINE_CODE);
  assign eff_attr    = (attr_q == 8'd0) ? def_attr_q : attr_q;
  assign at_last_col = (col_q == CW'(COLUMNS - 1));
  assign at_last_row = (row_q == RW'(ROWS - 1));
  assign wrap        = is_newline || at_last_col;
  assign scroll      = wrap && at_last_row;
  assign next_col    = wrap ? '0 : col_q + CW'(1);
  assign next_row    = (wrap && !at_last_row) ? row_q + RW'(1) : row_q;
  assign sweep_last  = (sweep_cnt_q == AW'(CELLS - 1));

  assign status_o.is_read       = is_read;
  assign status_o.scroll_needed = is_write && scroll;
  assign status_o.sweep_last    = sweep_last;

  // Write port: a cell write during execution, otherwise the delayed sweep write.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr_q;
    mem_wd = '0;
    if (cmd_i.exec && is_write && !is_newline) begin
      mem_we = 1'b1;
      mem_wa = cell_addr;
      mem_wd = {eff_attr, char_q};
    end else if (wr_pend_q) begin
      mem_we = 1'b1;
      mem_wd = wr_zero_q ? 16'd0 : rdata_q;
    end
  end

  // Read port: the addressed cell, or the cell one row below the sweep position.
  always_comb begin
    if (cmd_i.exec) begin
      mem_ra = cell_addr;
    end else if (32'(sweep_cnt_q) < MOVE) begin
      mem_ra = AW'(32'(sweep_cnt_q) + COLUMNS);
    end else begin
      mem_ra = '0;
    end
  end

  // Cell memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  // Captured word, sweep write address and result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= item_i.operation;
      col_q  <= cap_col;
      row_q  <= cap_row;
      char_q <= item_i.char_code;
      attr_q <= item_i.attribute;
    end
    wr_addr_q <= sweep_cnt_q;
    wr_zero_q <= cmd_i.sweep_clear || (32'(sweep_cnt_q) >= MOVE);
    if (cmd_i.exec && !is_read) begin
      res_q.cell_char      <= (is_write && !is_newline) ? char_q : 8'd0;
      res_q.cell_attribute <= (is_write && !is_newline) ? eff_attr : 8'd0;
      res_q.cursor_column  <= is_write ? 7'(next_col) : 7'(cur_col_q);
      res_q.cursor_row     <= is_write ? 5'(next_row) : 5'(cur_row_q);
      res_q.scrolled       <= is_write && scroll;
    end else if (cmd_i.load_read) begin
      res_q.cell_char      <= rdata_q[7:0];
      res_q.cell_attribute <= rdata_q[15:8];
      res_q.cursor_column  <= 7'(cur_col_q);
      res_q.cursor_row     <= 5'(cur_row_q);
      res_q.scrolled       <= 1'b0;
    end
  end

  // Control state: cursor, default attribute, sweep counter, strobes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      def_attr_q  <= tcw_pkg::DEFAULT_ATTR_RESET;
      sweep_cnt_q <= '0;
      wr_pend_q   <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        def_attr_q <= cfg_data_i;
      end
      if (cmd_i.exec && is_write) begin
        cur_col_q <= next_col;
        cur_row_q <= next_row;
      end
      if (cmd_i.sweep) begin
        sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + AW'(1);
      end
      wr_pend_q <= cmd_i.sweep;
      strobe_q  <= (cmd_i.exec && !is_read) || cmd_i.load_read;
    end
  end

  assign result_o        = res_q;
  assign result_strobe_o = strobe_q;

endmodule

`default_nettype wire

// File: src/tcw_ctrl.sv
// Controller of the text console writer: sequences clearing, execution,
// reads and scroll sweeps. Uses tcw_pkg for the command and status bundles.
`default_nettype none

module tcw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire tcw_pkg::status_t  status_i,
  output tcw_pkg::cmd_t          cmd_o,
  output logic                   busy
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep       = 1'b1;
        cmd_o.sweep_clear = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.is_read) begin
          state_d = ST_RDWAIT;
        end else if (status_i.scroll_needed) begin
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        cmd_o.load_read = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last delayed sweep write lands in this cycle.
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: src/text_console_writer.sv
// Text console writer top level: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and text_console_writer_macros.svh.
//
// Usage:
// - Command channel: a word on item_i is taken at a rising edge with start high
//   and busy low. Operations are write at cursor, write at position and read cell.
// - Result channel: each word gives exactly one result on result_o, shown for one
//   cycle with result_strobe_o high. The receiver cannot stall it.
// - Configuration: cfg_data_i is written to the default attribute at an edge
//   with cfg_valid_i and cfg_ready_o high; cfg_ready_o is always high.
// - Sequence: a write or an unused operation gives its result from the EXEC state,
//   as busy drops; a read waits in RDWAIT for the registered memory read port
//   and gives its result as busy drops.
// - A write that runs past the last cell scrolls the screen: the result comes out
//   as usual, then busy stays high through the SWEEP and DRAIN states while one
//   cell a cycle is moved up one row and the bottom row is zeroed.
// - Reset: the cursor goes to the top left, the default attribute to 15, and a
//   clearing pass through the CLEAR and DRAIN states zeroes the memory with busy high.
`default_nettype none
`include "text_console_writer_macros.svh"

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire tcw_pkg::item_t    item_i,
  output tcw_pkg::result_t       result_o,
  output logic                   result_strobe_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_data_i
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  // The default attribute register takes a word at any time.
  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

  // A result strobe lasts a single cycle.
  `TCW_ASSERT_NEXT(a_strobe_single, result_strobe_o, !result_strobe_o, "strobe held two cycles")

  // An accepted word keeps the block busy and shows no result in the next cycle.
  `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !result_strobe_o, "accept not followed by busy")

  // A scroll always leaves the cursor at the start of a row.
  `TCW_ASSERT_NOW(a_scroll_col0, result_strobe_o && result_o.scrolled, result_o.cursor_column == 7'd0, "scroll with cursor off column zero")

  // The reported cursor row stays inside the grid.
  `TCW_ASSERT_NOW(a_row_range, result_strobe_o, 32'(result_o.cursor_row) < ROWS, "cursor row out of range")

endmodule

`default_nettype wire

// File: bench/text_console_writer_tb.sv
// Self-checking testbench for the text console writer: directed edge cases,
// default attribute settings and random command traffic against a local screen model.
// Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_TOTAL = COLUMNS * ROWS;

  // The fourth operation code has no name in the package; the block ignores it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  tcw_pkg::item_t   item_i      = '0;
  tcw_pkg::result_t result_o;
  logic             result_strobe_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [7:0]       cfg_data_i  = '0;

  // Screen model: character in the low byte, attribute in the high byte.
  logic [15:0] screen_cells [CELL_TOTAL];
  int unsigned cursor_pos;
  logic [7:0]  default_attr;

  tcw_pkg::result_t pending_results [$];
  tcw_pkg::result_t oldest_result;
  int               mismatch_count;
  int               sender_idle_pct;

  always #5 clk_i = ~clk_i;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_strobe_o(result_strobe_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Column and row beyond the screen are pinned to the last column and row.
  function automatic int unsigned cell_index(logic [6:0] col, logic [4:0] rw);
    int unsigned c;
    int unsigned r;
    c = (col >= COLUMNS) ? COLUMNS - 1 : col;
    r = (rw >= ROWS) ? ROWS - 1 : rw;
    return r * COLUMNS + c;
  endfunction

  // Applies one command word to the screen model and returns the result it should give.
  function automatic tcw_pkg::result_t apply_console_command(tcw_pkg::item_t it);
    tcw_pkg::result_t res;
    int unsigned      pos;
    int unsigned      next_pos;
    logic [7:0]       attr;
    res  = '0;
    attr = (it.attribute == 8'd0) ? default_attr : it.attribute;
    case (it.operation)
      tcw_pkg::OP_READ: begin
        pos                = cell_index(it.column, it.row);
        res.cell_char      = screen_cells[pos][7:0];
        res.cell_attribute = screen_cells[pos][15:8];
      end
      tcw_pkg::OP_WRITE_CURSOR, tcw_pkg::OP_WRITE_AT: begin
        pos = (it.operation == tcw_pkg::OP_WRITE_AT) ? cell_index(it.column, it.row)
                                                     : cursor_pos;
        if (it.char_code == tcw_pkg::NEWLINE_CODE) begin
          next_pos = (pos / COLUMNS + 1) * COLUMNS;
        end else begin
          screen_cells[pos]  = {attr, it.char_code};
          res.cell_char      = it.char_code;
          res.cell_attribute = attr;
          next_pos           = pos + 1;
        end
        // Running off the last cell moves every row up and blanks the bottom row.
        if (next_pos >= CELL_TOTAL) begin
          for (int i = 0; i < CELL_TOTAL - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
          for (int i = CELL_TOTAL - COLUMNS; i < CELL_TOTAL; i++) screen_cells[i] = '0;
          next_pos    -= COLUMNS;
          res.scrolled = 1'b1;
        end
        cursor_pos = next_pos;
      end
      default: ;
    endcase
    res.cursor_column = 7'(cursor_pos % COLUMNS);
    res.cursor_row    = 5'(cursor_pos / COLUMNS);
    return res;
  endfunction

  function automatic tcw_pkg::item_t make_item(logic [1:0] op, logic [6:0] col, logic [4:0] rw,
                                               logic [7:0] ch, logic [7:0] attr);
    tcw_pkg::item_t it;
    it.operation = op;
    it.column    = col;
    it.row       = rw;
    it.char_code = ch;
    it.attribute = attr;
    return it;
  endfunction

  // Random word: mostly writes and reads near the cursor, with bias toward the
  // bottom right so that newlines and writes regularly scroll the screen.
  function automatic tcw_pkg::item_t random_item();
    tcw_pkg::item_t it;
    int unsigned    pick;
    int unsigned    cur_col;
    int unsigned    back;
    pick = $urandom_range(99);
    it   = make_item(tcw_pkg::OP_WRITE_CURSOR, 7'($urandom_range(COLUMNS - 1)),
                     5'($urandom_range(ROWS - 1)), 8'($urandom_range(255)),
                     ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)));
    if (pick < 45) begin
      if ($urandom_range(4) == 0) it.char_code = tcw_pkg::NEWLINE_CODE;
    end else if (pick < 65) begin
      it.operation = tcw_pkg::OP_WRITE_AT;
      if ($urandom_range(1) == 0) it.row = 5'(ROWS - 1);
      if ($urandom_range(3) == 0) it.column = 7'(COLUMNS - 1);
      if ($urandom_range(9) == 0) it.char_code = tcw_pkg::NEWLINE_CODE;
    end else if (pick < 95) begin
      it.operation = tcw_pkg::OP_READ;
      // Half the reads look just behind the cursor, where recent writes landed.
      if ($urandom_range(1) == 0) begin
        cur_col   = cursor_pos % COLUMNS;
        back      = $urandom_range(3);
        it.column = 7'((back > cur_col) ? 0 : cur_col - back);
        it.row    = 5'(cursor_pos / COLUMNS);
      end
    end else begin
      it.operation = OP_UNUSED;
    end
    if ($urandom_range(19) == 0) begin
      it.column = 7'($urandom_range(127));
      it.row    = 5'($urandom_range(31));
    end
    return it;
  endfunction

  // Offers one command word, with random idle cycles first, and records its
  // expected result at the edge where the block takes it.
  task automatic send_item(input tcw_pkg::item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(apply_console_command(it));
  endtask

  task automatic wait_until_idle();
    @(posedge clk_i);
    while (busy || pending_results.size() != 0) @(posedge clk_i);
  endtask

  // The register is only written with no command in flight and no scroll running.
  task automatic write_default_attribute(input logic [7:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    wait_until_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    default_attr = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      mismatch_count++;
    end
  endtask

  // Every strobed result word is compared with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: %h", result_o);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("cell_char", oldest_result.cell_char, result_o.cell_char);
        check_field("cell_attribute", oldest_result.cell_attribute, result_o.cell_attribute);
        check_field("cursor_column", oldest_result.cursor_column, result_o.cursor_column);
        check_field("cursor_row", oldest_result.cursor_row, result_o.cursor_row);
        check_field("scrolled", oldest_result.scrolled, result_o.scrolled);
      end
    end
  end

  // Field extremes, newline, clamping, both kinds of scroll and the unused operation.
  task automatic test_directed_edges();
    send_item(make_item(tcw_pkg::OP_READ, 7'd0, 5'd0, 8'd0, 8'd0));
    send_item(make_item(tcw_pkg::OP_WRITE_CURSOR, 7'd0, 5'd0, 8'h41, 8'd0));
    send_item(make_item(tcw_pkg::OP_WRITE_CURSOR, 7'd127, 5'd31, 8'd255, 8'd255));
    send_item(make_item(tcw_pkg::OP_WRITE_CURSOR, 7'd0, 5'd0, 8'd0, 8'd1));
    send_item(make_item(tcw_pkg::OP_READ, 7'd0, 5'd0, 8'd255, 8'd255));
    send_item(make_item(tcw_pkg::OP_READ, 7'd1, 5'd0, 8'd0, 8'd0));
    send_item(make_item(tcw_pkg::OP_WRITE_AT, 7'd79, 5'd0, 8'h5a, 8'h70));
    send_item(make_item(tcw_pkg::OP_WRITE_CURSOR, 7'd0, 5'd0, tcw_pkg::NEWLINE_CODE, 8'h22));
    send_item(make_item(tcw_pkg::OP_WRITE_AT, 7'd5, 5'd3, tcw_pkg::NEWLINE_CODE, 8'd0));
    send_item(make_item(tcw_pkg::OP_WRITE_CURSOR, 7'd0, 5'd0, 8'h42, 8'h1e));
    send_item(make_item(tcw_pkg::OP_WRITE_AT, 7'd100, 5'd2, 8'h43, 8'h2f));
    send_item(make_item(tcw_pkg::OP_READ, 7'd79, 5'd2, 8'd0, 8'd0));
    send_item(make_item(tcw_pkg::OP_WRITE_AT, 7'd3, 5'd30, 8'h44, 8'h3c));
    send_item(make_item(tcw_pkg::OP_READ, 7'd3, 5'd24, 8'd0, 8'd0));
    // A write into the last cell scrolls, even when both coordinates are clamped.
    send_item(make_item(tcw_pkg::OP_WRITE_AT, 7'd127, 5'd31, 8'h58, 8'h4b));
    send_item(make_item(tcw_pkg::OP_READ, 7'd127, 5'd31, 8'd0, 8'd0));
    send_item(make_item(tcw_pkg::OP_READ, 7'd79, 5'd23, 8'd0, 8'd0));
    send_item(make_item(tcw_pkg::OP_READ, 7'd3, 5'd23, 8'd0, 8'd0));
    // A newline on the bottom row scrolls without writing a cell.
    send_item(make_item(tcw_pkg::OP_WRITE_AT, 7'd10, 5'd24, tcw_pkg::NEWLINE_CODE, 8'd0));
    send_item(make_item(tcw_pkg::OP_READ, 7'd79, 5'd22, 8'd0, 8'd0));
    send_item(make_item(OP_UNUSED, 7'd127, 5'd31, 8'd255, 8'd255));
    send_item(make_item(OP_UNUSED, 7'd0, 5'd0, 8'd0, 8'd0));
    send_item(make_item(tcw_pkg::OP_WRITE_CURSOR, 7'd0, 5'd0, 8'h7e, 8'd0));
    send_item(make_item(tcw_pkg::OP_READ, 7'd0, 5'd24, 8'd0, 8'd0));
  endtask

  // A zero attribute picks up each default setting, the extremes among them.
  task automatic test_default_attribute();
    logic [7:0]  settings [3];
    int unsigned pos;
    settings = '{8'd0, 8'd255, 8'($urandom_range(1, 254))};
    foreach (settings[i]) begin
      write_default_attribute(settings[i]);
      pos = cursor_pos;
      send_item(make_item(tcw_pkg::OP_WRITE_CURSOR, 7'd0, 5'd0,
                          8'($urandom_range(11, 255)), 8'd0));
      send_item(make_item(tcw_pkg::OP_READ, 7'(pos % COLUMNS), 5'(pos / COLUMNS),
                          8'd0, 8'd0));
      send_item(make_item(tcw_pkg::OP_WRITE_AT, 7'd40, 5'd12, 8'h61, 8'd0));
      send_item(make_item(tcw_pkg::OP_READ, 7'd40, 5'd12, 8'd0, 8'd0));
    end
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_item(random_item());
  endtask

  initial begin
    foreach (screen_cells[i]) screen_cells[i] = '0;
    cursor_pos      = 0;
    default_attr    = tcw_pkg::DEFAULT_ATTR_RESET;
    mismatch_count  = 0;
    sender_idle_pct = 6;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_default_attribute();
    write_default_attribute(8'd0);
    test_random_traffic(140, 6);
    write_default_attribute(8'd255);
    test_random_traffic(140, 71);
    write_default_attribute(8'($urandom_range(1, 254)));
    test_random_traffic(140, 0);

    // Drain outstanding results and any scroll still running.
    @(negedge clk_i);
    start <= 1'b0;
    wait_until_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond a run where every word scrolls the whole screen.
  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: text_console_writer.f
+incdir+src
src/tcw_pkg.sv
src/tcw_datapath.sv
src/tcw_ctrl.sv
src/text_console_writer.sv
bench/text_console_writer_tb.sv
